/* hdl/brns_pkg.sv */
package brns_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int MAX_DIMS    = 3;
    localparam int MASK_BITS   = 64;
    localparam int COORD_WIDTH = 16;
    localparam int GROUP_W     = 16;
    localparam int RADIUS_W    = 16;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int LANE_W  = $clog2(MASK_BITS);
    localparam int ROWS    = MAX_POINTS / MASK_BITS;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W = MAX_DIMS * COORD_WIDTH + GROUP_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIMS_W     = 2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_COUNT = 3'd0,
        CFG_DIMS_IN_USE = 3'd1,
        CFG_RADIUS_0    = 3'd2,
        CFG_RADIUS_1    = 3'd3,
        CFG_RADIUS_2    = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SWEEP
    } t_state;

endpackage

/* hdl/box_radius_neighbor_search.sv */
// Box-radius neighbor search over a store of 1024 points. A load beat (kind 0) writes
// the point's three coordinates and group label at point_index. A query beat (kind 1)
// names a stored point and yields ceil(n/64) result beats, n being point_count clamped
// to 1..1024, each a 64-bit membership mask of the neighbors among 64 consecutive
// points, lowest chunk first, the final one flagged with last. A point is a neighbor when
// its group label equals the query's and every compared coordinate lies within that
// dimension's radius; bits at or beyond n are zero. The store is 64 banks of 16 rows, so
// one row of 64 points is read per cycle while i_out_stall does not hold the output: a
// query first reads and latches its own entry, then sweeps one row per mask beat.
// Input is not taken during a query; the last mask may wait in the output register
// while the next beat is accepted. Never-loaded entries read as arbitrary data.
// Configuration writes complete at once and must only occur while the block is idle.
module box_radius_neighbor_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [brns_pkg::IDX_W-1:0]          i_point_index,
    input  logic signed [brns_pkg::COORD_WIDTH-1:0] i_coord_0,
    input  logic signed [brns_pkg::COORD_WIDTH-1:0] i_coord_1,
    input  logic signed [brns_pkg::COORD_WIDTH-1:0] i_coord_2,
    input  logic [brns_pkg::GROUP_W-1:0]        i_group_id,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [brns_pkg::IDX_W-1:0]          o_query_index,
    output logic [brns_pkg::ROW_W-1:0]          o_chunk_index,
    output logic [brns_pkg::MASK_BITS-1:0]      o_neighbor_mask,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [brns_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [brns_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW = brns_pkg::COORD_WIDTH;

    brns_pkg::t_state r_state, n_state;

    logic [brns_pkg::CNT_W-1:0]    r_point_count;
    logic [brns_pkg::DIMS_W-1:0]   r_dims;
    logic [brns_pkg::RADIUS_W-1:0] r_radius [brns_pkg::MAX_DIMS];

    logic [brns_pkg::IDX_W-1:0]    r_qidx;
    logic [brns_pkg::ENTRY_W-1:0]  r_q;
    logic [brns_pkg::ROW_W-1:0]    r_chunk;
    logic [brns_pkg::ENTRY_W-1:0]  r_rd [brns_pkg::MASK_BITS];

    logic                          r_out_valid;
    logic [brns_pkg::IDX_W-1:0]    r_out_qidx;
    logic [brns_pkg::ROW_W-1:0]    r_out_chunk;
    logic [brns_pkg::MASK_BITS-1:0] r_out_mask;
    logic                          r_out_last;

    logic                          in_acc;
    logic                          load_we;
    logic                          adv;
    logic [brns_pkg::ROW_W-1:0]    rd_row;
    logic [brns_pkg::CNT_W-1:0]    cnt_eff;
    logic [brns_pkg::ROW_W-1:0]    last_chunk;
    logic [brns_pkg::MAX_DIMS-1:0] dim_on;
    logic [brns_pkg::MASK_BITS-1:0] mask;
    logic [brns_pkg::ENTRY_W-1:0]  wdata;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign load_we = in_acc && (i_kind == brns_pkg::KIND_LOAD);
    assign adv     = (r_state == brns_pkg::S_SWEEP) && (!r_out_valid || !i_out_stall);
    assign wdata   = {i_group_id, i_coord_2, i_coord_1, i_coord_0};

    // effective count and dims
    always_comb begin
        priority if (r_point_count == '0) begin
            cnt_eff = brns_pkg::CNT_W'(1);
        end else if (r_point_count > brns_pkg::CNT_W'(brns_pkg::MAX_POINTS)) begin
            cnt_eff = brns_pkg::CNT_W'(brns_pkg::MAX_POINTS);
        end else begin
            cnt_eff = r_point_count;
        end
        last_chunk = brns_pkg::ROW_W'((cnt_eff - brns_pkg::CNT_W'(1)) >> brns_pkg::LANE_W);
        for (int d = 0; d < brns_pkg::MAX_DIMS; d++) begin
            dim_on[d] = (d == 0) || (int'(r_dims) > d);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brns_pkg::S_IDLE: begin
                if (in_acc && (i_kind == brns_pkg::KIND_QUERY)) begin
                    n_state = brns_pkg::S_FETCH;
                end
            end
            brns_pkg::S_FETCH: begin
                n_state = brns_pkg::S_SWEEP;
            end
            brns_pkg::S_SWEEP: begin
                if (adv && (r_chunk == last_chunk)) begin
                    n_state = brns_pkg::S_IDLE;
                end
            end
            default: n_state = brns_pkg::S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_in_stall = 1'b1;
        rd_row     = r_chunk;
        unique case (r_state)
            brns_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                rd_row     = i_point_index[brns_pkg::IDX_W-1:brns_pkg::LANE_W];
            end
            brns_pkg::S_FETCH: begin
                rd_row = '0;
            end
            brns_pkg::S_SWEEP: begin
                rd_row = adv ? r_chunk + brns_pkg::ROW_W'(1) : r_chunk;
            end
            default: rd_row = r_chunk;
        endcase
    end

    // point banks, one per mask bit
    for (genvar k = 0; k < brns_pkg::MASK_BITS; k++) begin : g_bank
        logic [brns_pkg::ENTRY_W-1:0] r_mem [brns_pkg::ROWS];
        always_ff @(posedge i_clk) begin
            if (load_we && (i_point_index[brns_pkg::LANE_W-1:0] == brns_pkg::LANE_W'(k))) begin
                r_mem[i_point_index[brns_pkg::IDX_W-1:brns_pkg::LANE_W]] <= wdata;
            end
            r_rd[k] <= r_mem[rd_row];
        end
    end

    // compare one row against the query point
    always_comb begin
        logic                         hit;
        logic signed [CW:0]           diff;
        logic [CW:0]                  mag;
        logic [CW-1:0]                a;
        logic [CW-1:0]                b;
        logic [brns_pkg::IDX_W-1:0]   p;
        for (int k = 0; k < brns_pkg::MASK_BITS; k++) begin
            hit = (r_rd[k][brns_pkg::ENTRY_W-1 -: brns_pkg::GROUP_W] ==
                   r_q[brns_pkg::ENTRY_W-1 -: brns_pkg::GROUP_W]);
            for (int d = 0; d < brns_pkg::MAX_DIMS; d++) begin
                a    = r_q[d*CW +: CW];
                b    = r_rd[k][d*CW +: CW];
                diff = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
                mag  = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
                if (dim_on[d] && (mag > {1'b0, r_radius[d]})) begin
                    hit = 1'b0;
                end
            end
            p = {r_chunk, brns_pkg::LANE_W'(k)};
            if ({1'b0, p} >= cnt_eff) begin
                hit = 1'b0;
            end
            mask[k] = hit;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= brns_pkg::S_IDLE;
            r_out_valid   <= 1'b0;
            r_point_count <= brns_pkg::CNT_W'(brns_pkg::MAX_POINTS);
            r_dims        <= brns_pkg::DIMS_W'(2);
            for (int d = 0; d < brns_pkg::MAX_DIMS; d++) begin
                r_radius[d] <= brns_pkg::RADIUS_W'(1);
            end
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (brns_pkg::t_cfg_reg'(i_cfg_index))
                    brns_pkg::CFG_POINT_COUNT: r_point_count <= i_cfg_data[brns_pkg::CNT_W-1:0];
                    brns_pkg::CFG_DIMS_IN_USE: r_dims <= i_cfg_data[brns_pkg::DIMS_W-1:0];
                    brns_pkg::CFG_RADIUS_0: r_radius[0] <= i_cfg_data[brns_pkg::RADIUS_W-1:0];
                    brns_pkg::CFG_RADIUS_1: r_radius[1] <= i_cfg_data[brns_pkg::RADIUS_W-1:0];
                    brns_pkg::CFG_RADIUS_2: r_radius[2] <= i_cfg_data[brns_pkg::RADIUS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_qidx <= i_point_index;
        end
        if (r_state == brns_pkg::S_FETCH) begin
            r_q     <= r_rd[r_qidx[brns_pkg::LANE_W-1:0]];
            r_chunk <= '0;
        end else if (adv) begin
            r_chunk <= r_chunk + brns_pkg::ROW_W'(1);
        end
        if (adv) begin
            r_out_qidx  <= r_qidx;
            r_out_chunk <= r_chunk;
            r_out_mask  <= mask;
            r_out_last  <= (r_chunk == last_chunk);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_query_index   = r_out_qidx;
    assign o_chunk_index   = r_out_chunk;
    assign o_neighbor_mask = r_out_mask;
    assign o_last          = r_out_last;
    assign o_cfg_ready     = 1'b1;

`ifndef SYNTH
    a_fetch_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brns_pkg::S_FETCH) |-> $past(r_state == brns_pkg::S_IDLE))
        else $error("fetch not entered from idle");

    a_chunk_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brns_pkg::S_SWEEP) && !adv |=> $stable(r_chunk))
        else $error("chunk moved while output blocked");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid &&
            $stable({o_query_index, o_chunk_index, o_neighbor_mask, o_last}))
        else $error("mask beat changed while stalled");
`endif

endmodule
